/* rtl/interpolation_search_table_defines.svh */
// ----------------------------------------------------------------------------
// interpolation search table defines
// assertion macros shared by the rtl files of the search table
// ----------------------------------------------------------------------------
`ifndef INTERPOLATION_SEARCH_TABLE_DEFINES_SVH
`define INTERPOLATION_SEARCH_TABLE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define IST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("interpolation search table assertion failed");
// next-cycle implication, checked outside reset
`define IST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("interpolation search table assertion failed");
`else
`define IST_ASSERT_NOW(label, ante, cons)
`define IST_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/ist_pkg.sv */
// ----------------------------------------------------------------------------
// ist_pkg
// shared constants, codes and control structs of the interpolation search table
// ----------------------------------------------------------------------------
package ist_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int VALUE_WIDTH = 32;

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int POS_W     = IDX_W + 2;
    localparam int DIFF_W    = VALUE_WIDTH + 1;
    localparam int NUM_W     = DIFF_W + IDX_W;
    localparam int DIV_STEPS = IDX_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    localparam int ENTRY_W     = 8;
    localparam int DATA_W      = 32;
    localparam int S_TDATA_W   = ENTRY_W + DATA_W;
    localparam int POSITION_W  = 8;
    localparam int M_TDATA_W   = POSITION_W;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_FIRST = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LAST  = 1'd1;

    localparam logic [CFG_DATA_W-1:0] WINDOW_FIRST_RESET = 8'd0;
    localparam logic [CFG_DATA_W-1:0] WINDOW_LAST_RESET  = 8'd255;

    typedef logic [1:0] rd_sel_t;
    localparam rd_sel_t RD_SEL_LOW   = 2'd0;
    localparam rd_sel_t RD_SEL_HIGH  = 2'd1;
    localparam rd_sel_t RD_SEL_PROBE = 2'd2;

    typedef struct packed {
        logic    wr_en;
        logic    start;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    cap_vlow;
        logic    cap_vhigh;
        logic    probe_low;
        logic    mul;
        logic    div_step;
        logic    narrow;
        logic    set_hit;
        logic    emit;
    } ist_cmd_t;

    typedef struct packed {
        logic empty;
        logic out_range;
        logic ends_equal;
        logic div_last;
        logic hit;
    } ist_status_t;

endpackage

/* rtl/ist_datapath.sv */
// ----------------------------------------------------------------------------
// ist_datapath
// table memory, window registers, probe arithmetic and bit-serial divider
// ----------------------------------------------------------------------------
`include "interpolation_search_table_defines.svh"

module ist_datapath
    import ist_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  ist_cmd_t               cmd,
    output ist_status_t            status,
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tuser
);

    logic [ENTRY_W-1:0]             entry_index;
    logic [DATA_W-1:0]              data_value;
    logic signed [VALUE_WIDTH-1:0]  in_value;

    logic signed [VALUE_WIDTH-1:0]  mem [TABLE_DEPTH];
    logic signed [VALUE_WIDTH-1:0]  rdata_reg;
    logic [IDX_W-1:0]               rd_addr;
    logic                           wr_ok;

    logic [CFG_DATA_W-1:0]          window_first_reg;
    logic [CFG_DATA_W-1:0]          window_last_reg;

    logic signed [VALUE_WIDTH-1:0]  key_reg;
    logic signed [VALUE_WIDTH-1:0]  vlow_reg;
    logic signed [VALUE_WIDTH-1:0]  vhigh_reg;
    logic [POS_W-1:0]               low_reg;
    logic [POS_W-1:0]               high_reg;
    logic [POS_W-1:0]               high_init;
    logic [IDX_W-1:0]               probe_reg;

    logic signed [DIFF_W-1:0]       diff_key;
    logic signed [DIFF_W-1:0]       diff_end;
    logic [IDX_W-1:0]               span;
    logic [NUM_W-1:0]               prod;

    logic [NUM_W-1:0]               rem_reg;
    logic [NUM_W-1:0]               rem_next;
    logic [NUM_W-1:0]               dsh_reg;
    logic [IDX_W-1:0]               q_reg;
    logic [IDX_W-1:0]               q_next;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           ge;

    logic                           res_found_reg;
    logic [POSITION_W-1:0]          res_pos_reg;
    logic [M_TDATA_W-1:0]           m_tdata_reg;
    logic                           m_tuser_reg;

    assign entry_index = s_tdata[ENTRY_W-1:0];
    assign data_value  = s_tdata[S_TDATA_W-1:ENTRY_W];
    assign in_value    = VALUE_WIDTH'(data_value);
    assign wr_ok       = 32'(entry_index) < TABLE_DEPTH;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_first_reg <= WINDOW_FIRST_RESET;
            window_last_reg  <= WINDOW_LAST_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WINDOW_FIRST: window_first_reg <= cfg_data;
                REG_WINDOW_LAST:  window_last_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // table memory
    always_comb begin
        case (cmd.rd_sel)
            RD_SEL_LOW:   rd_addr = low_reg[IDX_W-1:0];
            RD_SEL_HIGH:  rd_addr = high_reg[IDX_W-1:0];
            RD_SEL_PROBE: rd_addr = probe_reg;
            default:      rd_addr = probe_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && wr_ok) begin
            mem[IDX_W'(entry_index)] <= in_value;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // window and probe arithmetic
    assign high_init = (POS_W'(window_last_reg) > POS_W'(TABLE_DEPTH - 1))
                     ? POS_W'(TABLE_DEPTH - 1) : POS_W'(window_last_reg);

    assign diff_key = DIFF_W'(key_reg) - DIFF_W'(vlow_reg);
    assign diff_end = DIFF_W'(vhigh_reg) - DIFF_W'(vlow_reg);
    assign span     = IDX_W'(high_reg - low_reg);
    assign prod     = $unsigned(diff_key) * span;

    assign ge       = rem_reg >= dsh_reg;
    assign rem_next = ge ? (rem_reg - dsh_reg) : rem_reg;
    assign q_next   = (q_reg << 1) | IDX_W'(ge);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            key_reg       <= in_value;
            low_reg       <= POS_W'(window_first_reg);
            high_reg      <= high_init;
            res_found_reg <= 1'b0;
            res_pos_reg   <= '0;
        end
        if (cmd.cap_vlow) begin
            vlow_reg <= rdata_reg;
        end
        if (cmd.cap_vhigh) begin
            vhigh_reg <= rdata_reg;
        end
        if (cmd.probe_low) begin
            probe_reg <= low_reg[IDX_W-1:0];
        end
        if (cmd.mul) begin
            rem_reg <= prod;
            dsh_reg <= NUM_W'($unsigned(diff_end)) << (DIV_STEPS - 1);
            q_reg   <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_next;
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= q_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (status.div_last) begin
                probe_reg <= low_reg[IDX_W-1:0] + q_next;
            end
        end
        if (cmd.narrow) begin
            if (key_reg < rdata_reg) begin
                high_reg <= POS_W'(probe_reg) - POS_W'(1);
            end else begin
                low_reg <= POS_W'(probe_reg) + POS_W'(1);
            end
        end
        if (cmd.set_hit) begin
            res_found_reg <= 1'b1;
            res_pos_reg   <= POSITION_W'(probe_reg);
        end
        if (cmd.emit) begin
            m_tdata_reg <= res_pos_reg;
            m_tuser_reg <= res_found_reg;
        end
    end

    assign status.empty      = $signed(low_reg) > $signed(high_reg);
    assign status.out_range  = (key_reg < vlow_reg) || (key_reg > vhigh_reg);
    assign status.ends_equal = vlow_reg == vhigh_reg;
    assign status.div_last   = cnt_reg == CNT_W'(DIV_STEPS - 1);
    assign status.hit        = key_reg == rdata_reg;

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    // quotient always fits the index width
    `IST_ASSERT_NEXT(a_quot_fits, cmd.mul, rem_reg < (dsh_reg << 1))
    // probe never leaves the current window
    `IST_ASSERT_NOW(a_probe_in_window, cmd.rd_en && (cmd.rd_sel == RD_SEL_PROBE),
        (POS_W'(probe_reg) >= low_reg) && (POS_W'(probe_reg) <= high_reg))

endmodule

/* rtl/ist_ctrl.sv */
// ----------------------------------------------------------------------------
// ist_ctrl
// search sequencer and output handshake of the interpolation search table
// ----------------------------------------------------------------------------
`include "interpolation_search_table_defines.svh"

module ist_ctrl
    import ist_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tuser,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  ist_status_t status,
    output ist_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_RD_LOW   = 4'd2;
    localparam logic [3:0] S_RD_HIGH  = 4'd3;
    localparam logic [3:0] S_EVAL     = 4'd4;
    localparam logic [3:0] S_DIV      = 4'd5;
    localparam logic [3:0] S_RD_PROBE = 4'd6;
    localparam logic [3:0] S_CMP      = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == OP_WRITE) begin
                        cmd.wr_en = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (status.empty) begin
                    state_next = S_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_SEL_LOW;
                    state_next = S_RD_LOW;
                end
            end
            S_RD_LOW: begin
                cmd.cap_vlow = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RD_SEL_HIGH;
                state_next   = S_RD_HIGH;
            end
            S_RD_HIGH: begin
                cmd.cap_vhigh = 1'b1;
                state_next    = S_EVAL;
            end
            S_EVAL: begin
                if (status.out_range) begin
                    state_next = S_DONE;
                end else if (status.ends_equal) begin
                    cmd.probe_low = 1'b1;
                    state_next    = S_RD_PROBE;
                end else begin
                    cmd.mul    = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = S_RD_PROBE;
                end
            end
            S_RD_PROBE: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SEL_PROBE;
                state_next = S_CMP;
            end
            S_CMP: begin
                if (status.hit) begin
                    cmd.set_hit = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    cmd.narrow = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // a search transfer blocks the input until its result is queued
    `IST_ASSERT_NEXT(a_search_blocks, s_tvalid && s_tready && (s_tuser == OP_SEARCH), !s_tready)
    // a pending result is never overwritten
    `IST_ASSERT_NOW(a_no_overwrite, cmd.emit, !m_tvalid_reg || m_tready)

endmodule

/* rtl/interpolation_search_table.sv */
// ----------------------------------------------------------------------------
// interpolation_search_table
// table of signed entries searched by interpolation over a configured window
// ----------------------------------------------------------------------------
// input stream: s_tuser selects the item kind (write entry or search key),
// s_tdata carries entry_index and data_value. a write transfer stores the
// value and gives no result; the next item is taken at once.
// a search transfer gives one result on the m_ stream: m_tuser is found,
// m_tdata the position (0 when not found).
// per probe a search runs a window check, two table reads for the window
// ends, a range check, an 8-step bit-serial divide, a probe read and a
// compare, all through one read port of the table memory (no divide when
// the window end values are equal). a miss ends at the window check or
// the range check. the result is then loaded into the output register,
// and the next item is accepted in the cycle after.
// the number of probes is 1 to 2 on evenly spread values and at most the
// window length. a stalled receiver holds only a following search at its end.
// the cfg channel writes window_first (index 0) and window_last (index 1)
// and is always ready; write it only while the block is idle.
// reset (aresetn low, synchronous) restores the window to the whole table
// and drops any pending result; table contents stay undefined until written.
// ----------------------------------------------------------------------------
module interpolation_search_table
    import ist_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // entry_index, data_value
    input  logic                   s_tuser,   // operation
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // position
    output logic                   m_tuser,   // found
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    ist_cmd_t    cmd;
    ist_status_t status;

    assign cfg_ready = 1'b1;

    ist_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ist_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
